[rtl/imusa_pkg.sv]
// Shared widths, constants, types and fixed-point helpers for the IMU alignment pipeline.
package imusa_pkg;

  localparam int SampleBits = 16;
  localparam int NumAxes    = 3;
  localparam int FracBits   = 16;
  localparam int BiasShift  = 12;

  // working values: counts with 16 fractional bits, headroom for two 45 degree steps
  localparam int WorkW     = SampleBits + 19;
  localparam int SumW      = WorkW + 1;
  localparam int IsqW      = 17;
  localparam int IsqProdW  = SumW + IsqW;
  localparam int ScaleW    = 24;
  localparam int GyroProdW = SumW + ScaleW;
  localparam int GyroShift = 32;

  localparam int AccelW   = 22;
  localparam int GyroW    = 23;
  localparam int FlagsW   = 6;
  localparam int BiasW    = 15;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  localparam int InW      = 2 * NumAxes * SampleBits;
  localparam int InBusW   = ((InW + 7) / 8) * 8;
  localparam int OutW     = NumAxes * AccelW + NumAxes * GyroW;
  localparam int OutBusW  = ((OutW + 7) / 8) * 8;

  localparam logic signed [IsqW-1:0]   InvSqrt2  = 17'sd46341;
  localparam logic signed [ScaleW-1:0] GyroScale = 24'sd4575276;

  localparam logic signed [63:0] AccelMin = -64'sd2097152;
  localparam logic signed [63:0] AccelMax = 64'sd2097151;
  localparam logic signed [63:0] GyroMin  = -64'sd4194304;
  localparam logic signed [63:0] GyroMax  = 64'sd4194303;

  // orientation flag bit positions, applied in this order
  localparam int FlagRot90Cw  = 0;
  localparam int FlagRot45Ccw = 1;
  localparam int FlagRot45Cw  = 2;
  localparam int FlagRot90Ccw = 3;
  localparam int FlagRot180   = 4;
  localparam int FlagFlip     = 5;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegOrient     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAccelBiasX = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAccelBiasY = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAccelBiasZ = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGyroBiasX  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGyroBiasY  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGyroBiasZ  = 3'd6;

  typedef logic signed [WorkW-1:0]     work_t;
  typedef logic signed [SumW-1:0]      sum_t;
  typedef logic signed [IsqProdW-1:0]  isq_prod_t;
  typedef logic signed [GyroProdW-1:0] gyro_prod_t;
  typedef logic signed [BiasW-1:0]     bias_t;

  typedef struct packed {
    work_t z;
    work_t y;
    work_t x;
  } vec_t;

  typedef struct packed {
    logic adv_mul;
    logic adv_rnd;
    logic cw;
    logic active;
  } rot_ctrl_t;

  function automatic work_t to_work(logic [SampleBits-1:0] s);
    return {{(WorkW - SampleBits - FracBits){s[SampleBits-1]}}, s, {FracBits{1'b0}}};
  endfunction

  function automatic work_t bias_work(bias_t b);
    return {{(WorkW - BiasW - BiasShift){b[BiasW-1]}}, b, {BiasShift{1'b0}}};
  endfunction

  // round to nearest, ties up, drop 16 fractional bits of the 1/sqrt2 product
  function automatic work_t rnd_isq(isq_prod_t p);
    isq_prod_t t;
    t = p + (isq_prod_t'(1) <<< (FracBits - 1));
    return t[WorkW+FracBits-1:FracBits];
  endfunction

  function automatic logic [AccelW-1:0] sat_accel(logic signed [63:0] v);
    logic [AccelW-1:0] r;
    if (v < AccelMin) begin
      r = AccelMin[AccelW-1:0];
    end else if (v > AccelMax) begin
      r = AccelMax[AccelW-1:0];
    end else begin
      r = v[AccelW-1:0];
    end
    return r;
  endfunction

  function automatic logic [GyroW-1:0] sat_gyro(logic signed [63:0] v);
    logic [GyroW-1:0] r;
    if (v < GyroMin) begin
      r = GyroMin[GyroW-1:0];
    end else if (v > GyroMax) begin
      r = GyroMax[GyroW-1:0];
    end else begin
      r = v[GyroW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/imu_sample_alignment.sv]
// Throughput: one sample per cycle while the output is not stalled; eight register stages each hold a valid bit,
// so a stalled output fills empty stages before s_tready drops.
// The two 45 degree steps and the gyro scale multiply set the stage count.
// Reset clears all valid bits, the orientation flags and the six bias registers.
// Rounding is to nearest with ties up; results saturate to their field width.
module imu_sample_alignment (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [imusa_pkg::InBusW-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // accel_x_g, accel_y_g, accel_z_g, gyro_x_rate, gyro_y_rate, gyro_z_rate, zero pad
  output logic [imusa_pkg::OutBusW-1:0]     m_tdata,
  input  logic                              cfg_we,
  input  logic [imusa_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [imusa_pkg::CfgDataW-1:0]    cfg_data
);

  localparam int SB = imusa_pkg::SampleBits;

  logic [imusa_pkg::FlagsW-1:0] orient;
  imusa_pkg::bias_t             accel_bias [imusa_pkg::NumAxes];
  imusa_pkg::bias_t             gyro_bias  [imusa_pkg::NumAxes];

  logic [9:1] rdy;
  logic [8:1] vld;
  logic [8:1] vin;
  logic [8:1] ld;

  logic [imusa_pkg::FlagsW-1:0] f1, f2, f3, f4, f5;
  imusa_pkg::vec_t  a_ld, g_ld, a1, g1, a3, g3, a5, g5, a6, g6;
  imusa_pkg::work_t t;
  imusa_pkg::work_t t6;
  imusa_pkg::sum_t  acc_d [imusa_pkg::NumAxes];
  imusa_pkg::sum_t  gyr_s [imusa_pkg::NumAxes];
  logic [imusa_pkg::AccelW-1:0] acc_q6 [imusa_pkg::NumAxes];
  logic [imusa_pkg::AccelW-1:0] acc_q7 [imusa_pkg::NumAxes];
  imusa_pkg::gyro_prod_t gyr_p [imusa_pkg::NumAxes];
  logic [imusa_pkg::GyroW-1:0]  gyr_q [imusa_pkg::NumAxes];
  imusa_pkg::gyro_prod_t gyr_t [imusa_pkg::NumAxes];
  logic [imusa_pkg::SumW-1:0]   acc_t [imusa_pkg::NumAxes];
  logic [imusa_pkg::OutBusW-1:0] out_data;

  imusa_pkg::rot_ctrl_t ctrl_a, ctrl_b;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      orient <= '0;
      for (int i = 0; i < imusa_pkg::NumAxes; i++) begin
        accel_bias[i] <= '0;
        gyro_bias[i]  <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        imusa_pkg::RegOrient:     orient        <= cfg_data[imusa_pkg::FlagsW-1:0];
        imusa_pkg::RegAccelBiasX: accel_bias[0] <= cfg_data;
        imusa_pkg::RegAccelBiasY: accel_bias[1] <= cfg_data;
        imusa_pkg::RegAccelBiasZ: accel_bias[2] <= cfg_data;
        imusa_pkg::RegGyroBiasX:  gyro_bias[0]  <= cfg_data;
        imusa_pkg::RegGyroBiasY:  gyro_bias[1]  <= cfg_data;
        imusa_pkg::RegGyroBiasZ:  gyro_bias[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage flow control: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[9] = m_tready;
    for (int i = 8; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    vin = {vld[7:1], s_tvalid};
    ld  = vin & rdy[8:1];
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~rdy[8:1]) | (vin & rdy[8:1]);
    end
  end

  // stage 1: unpack, remove gyro bias, rotate 90 CW
  always_comb begin
    t      = '0;
    a_ld.x = imusa_pkg::to_work(s_tdata[0*SB +: SB]);
    a_ld.y = imusa_pkg::to_work(s_tdata[1*SB +: SB]);
    a_ld.z = imusa_pkg::to_work(s_tdata[2*SB +: SB]);
    g_ld.x = imusa_pkg::to_work(s_tdata[3*SB +: SB]) - imusa_pkg::bias_work(gyro_bias[0]);
    g_ld.y = imusa_pkg::to_work(s_tdata[4*SB +: SB]) - imusa_pkg::bias_work(gyro_bias[1]);
    g_ld.z = imusa_pkg::to_work(s_tdata[5*SB +: SB]) - imusa_pkg::bias_work(gyro_bias[2]);
    if (orient[imusa_pkg::FlagRot90Cw]) begin
      t      = a_ld.y;
      a_ld.y = a_ld.x;
      a_ld.x = -t;
      t      = g_ld.y;
      g_ld.y = -g_ld.x;
      g_ld.x = t;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      a1 <= a_ld;
      g1 <= g_ld;
      f1 <= orient;
    end
    if (ld[2]) f2 <= f1;
    if (ld[3]) f3 <= f2;
    if (ld[4]) f4 <= f3;
    if (ld[5]) f5 <= f4;
  end

  // stages 2-3: 45 CCW, stages 4-5: 45 CW
  always_comb begin
    ctrl_a.adv_mul = ld[2];
    ctrl_a.adv_rnd = ld[3];
    ctrl_a.cw      = 1'b0;
    ctrl_a.active  = f1[imusa_pkg::FlagRot45Ccw];
    ctrl_b.adv_mul = ld[4];
    ctrl_b.adv_rnd = ld[5];
    ctrl_b.cw      = 1'b1;
    ctrl_b.active  = f3[imusa_pkg::FlagRot45Cw];
  end

  imusa_rot45 u_rot_ccw (
    .clk   (clk),
    .ctrl  (ctrl_a),
    .a_in  (a1),
    .g_in  (g1),
    .a_out (a3),
    .g_out (g3)
  );

  imusa_rot45 u_rot_cw (
    .clk   (clk),
    .ctrl  (ctrl_b),
    .a_in  (a3),
    .g_in  (g3),
    .a_out (a5),
    .g_out (g5)
  );

  // stage 6: 90 CCW, 180, flip, accel bias, gyro output signs
  always_comb begin
    t6 = '0;
    a6 = a5;
    g6 = g5;
    if (f5[imusa_pkg::FlagRot90Ccw]) begin
      t6   = a6.y;
      a6.y = -a6.x;
      a6.x = t6;
      t6   = g6.y;
      g6.y = g6.x;
      g6.x = -t6;
    end
    if (f5[imusa_pkg::FlagRot180]) begin
      a6.x = -a6.x;
      a6.y = -a6.y;
      g6.x = -g6.x;
      g6.y = -g6.y;
    end
    if (f5[imusa_pkg::FlagFlip]) begin
      a6.x = -a6.x;
      a6.z = -a6.z;
      g6.y = -g6.y;
      g6.z = -g6.z;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      acc_d[0] <= imusa_pkg::sum_t'(a6.x) - imusa_pkg::sum_t'(imusa_pkg::bias_work(accel_bias[0]));
      acc_d[1] <= imusa_pkg::sum_t'(a6.y) - imusa_pkg::sum_t'(imusa_pkg::bias_work(accel_bias[1]));
      acc_d[2] <= imusa_pkg::sum_t'(a6.z) - imusa_pkg::sum_t'(imusa_pkg::bias_work(accel_bias[2]));
      gyr_s[0] <= imusa_pkg::sum_t'(g6.x);
      gyr_s[1] <= -imusa_pkg::sum_t'(g6.y);
      gyr_s[2] <= -imusa_pkg::sum_t'(g6.z);
    end
  end

  // stage 7: accel round and saturate, gyro scale multiply
  always_comb begin
    for (int i = 0; i < imusa_pkg::NumAxes; i++) begin
      acc_t[i]  = acc_d[i] + (imusa_pkg::sum_t'(1) <<< (imusa_pkg::BiasShift - 1));
      acc_q6[i] = imusa_pkg::sat_accel(
                    64'($signed(acc_t[i][imusa_pkg::SumW-1:imusa_pkg::BiasShift])));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      for (int i = 0; i < imusa_pkg::NumAxes; i++) begin
        acc_q7[i] <= acc_q6[i];
        gyr_p[i]  <= imusa_pkg::gyro_prod_t'(gyr_s[i]) *
                     imusa_pkg::gyro_prod_t'(imusa_pkg::GyroScale);
      end
    end
  end

  // stage 8: gyro round and saturate into the output register
  always_comb begin
    for (int i = 0; i < imusa_pkg::NumAxes; i++) begin
      gyr_t[i] = gyr_p[i] + (imusa_pkg::gyro_prod_t'(1) <<< (imusa_pkg::GyroShift - 1));
      gyr_q[i] = imusa_pkg::sat_gyro(
                   64'($signed(gyr_t[i][imusa_pkg::GyroProdW-1:imusa_pkg::GyroShift])));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      out_data <= imusa_pkg::OutBusW'({gyr_q[2], gyr_q[1], gyr_q[0],
                                       acc_q7[2], acc_q7[1], acc_q7[0]});
    end
  end

  assign m_tdata = out_data;

endmodule

[rtl/imusa_rot45.sv]
// Two-stage 45 degree rotation of the accel and gyro vectors: multiply, then round and place.
module imusa_rot45 (
  input  logic                  clk,
  input  imusa_pkg::rot_ctrl_t  ctrl,
  input  imusa_pkg::vec_t       a_in,
  input  imusa_pkg::vec_t       g_in,
  output imusa_pkg::vec_t       a_out,
  output imusa_pkg::vec_t       g_out
);

  imusa_pkg::sum_t      a_sum, a_dif, g_sum, g_dif;
  imusa_pkg::isq_prod_t a_ps, a_pd, g_ps, g_pd;
  imusa_pkg::vec_t      a_hold, g_hold;
  imusa_pkg::vec_t      a_new, g_new;
  logic                 active_m;

  // cw step takes y - x, ccw step takes x - y; both sensors share the choice
  always_comb begin
    a_sum = imusa_pkg::sum_t'(a_in.x) + imusa_pkg::sum_t'(a_in.y);
    g_sum = imusa_pkg::sum_t'(g_in.x) + imusa_pkg::sum_t'(g_in.y);
    if (ctrl.cw) begin
      a_dif = imusa_pkg::sum_t'(a_in.y) - imusa_pkg::sum_t'(a_in.x);
      g_dif = imusa_pkg::sum_t'(g_in.y) - imusa_pkg::sum_t'(g_in.x);
    end else begin
      a_dif = imusa_pkg::sum_t'(a_in.x) - imusa_pkg::sum_t'(a_in.y);
      g_dif = imusa_pkg::sum_t'(g_in.x) - imusa_pkg::sum_t'(g_in.y);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv_mul) begin
      a_ps     <= imusa_pkg::isq_prod_t'(a_sum) * imusa_pkg::isq_prod_t'(imusa_pkg::InvSqrt2);
      a_pd     <= imusa_pkg::isq_prod_t'(a_dif) * imusa_pkg::isq_prod_t'(imusa_pkg::InvSqrt2);
      g_ps     <= imusa_pkg::isq_prod_t'(g_sum) * imusa_pkg::isq_prod_t'(imusa_pkg::InvSqrt2);
      g_pd     <= imusa_pkg::isq_prod_t'(g_dif) * imusa_pkg::isq_prod_t'(imusa_pkg::InvSqrt2);
      a_hold   <= a_in;
      g_hold   <= g_in;
      active_m <= ctrl.active;
    end
  end

  // accel negates the difference term, gyro keeps it
  always_comb begin
    a_new = a_hold;
    g_new = g_hold;
    if (active_m) begin
      if (ctrl.cw) begin
        a_new.y = imusa_pkg::rnd_isq(a_ps);
        a_new.x = -imusa_pkg::rnd_isq(a_pd);
        g_new.x = imusa_pkg::rnd_isq(g_ps);
        g_new.y = imusa_pkg::rnd_isq(g_pd);
      end else begin
        a_new.x = imusa_pkg::rnd_isq(a_ps);
        a_new.y = -imusa_pkg::rnd_isq(a_pd);
        g_new.y = imusa_pkg::rnd_isq(g_ps);
        g_new.x = imusa_pkg::rnd_isq(g_pd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv_rnd) begin
      a_out <= a_new;
      g_out <= g_new;
    end
  end

endmodule

[rtl/imusa_checker.sv]
// Port-level checks for the IMU alignment pipeline, bound to the top level.
module imusa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [imusa_pkg::OutBusW-1:0] m_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // drop a result only after its transfer
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) && !$past(rst) |-> $past(m_tready))
    else $error("result dropped without transfer");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a draining output keeps the input open
  a_flow: assert property (@(posedge clk)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

endmodule

bind imu_sample_alignment imusa_checker u_imusa_checker (.*);
